@@ sv/tcce_pkg.sv @@
// Shared types and constants for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned BG_W    = 3;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned OFF_W   = 11;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned FG_W    = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [OP_W-1:0] OP_PRINT = 2'd0;
  localparam logic [OP_W-1:0] OP_GOTO  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [FG_W-1:0]   FG_RESET   = 4'hF;
  localparam logic [BG_W-1:0]   BG_RESET   = 3'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 1'b1;

  typedef enum logic [2:0] {
    K_PRINT,
    K_TAB,
    K_NEWLINE,
    K_GOTO,
    K_CLEAR,
    K_READ
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [CHAR_W-1:0]   chr;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [ATTR_W-1:0]   fill_attr;
    logic [IDX_W-1:0]    idx;
    logic                hit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } qhead_t;

  typedef struct packed {
    logic init_busy;
  } stat_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [OFF_W-1:0]  offset;
    logic              wrap;
    logic [DATA_W-1:0] rdata;
  } res_t;

endpackage

@@ sv/tcce_front.sv @@
// Front end: decodes an input word into a command for the back end.
`timescale 1ns / 1ps

module tcce_front #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic [tcce_pkg::OP_W-1:0]   op_i,
  input  logic [tcce_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcce_pkg::COL_W-1:0]  column_i,
  input  logic [tcce_pkg::ROW_W-1:0]  row_i,
  input  logic [tcce_pkg::BG_W-1:0]   clear_background_i,
  input  logic                        use_clear_background_i,
  input  logic [tcce_pkg::IDX_W-1:0]  cell_index_i,
  input  logic [tcce_pkg::ATTR_W-1:0] attr_i,
  output tcce_pkg::cmd_t              cmd_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;

  logic goto_ok;
  logic read_ok;

  assign goto_ok = (column_i != '0) && (32'(column_i) <= COLUMNS) &&
                   (row_i != '0) && (32'(row_i) <= ROWS);
  assign read_ok = 32'(cell_index_i) < CELLS;

  always_comb begin
    cmd_o.chr       = char_code_i;
    cmd_o.col       = column_i;
    cmd_o.row       = row_i;
    cmd_o.idx       = cell_index_i;
    cmd_o.fill_attr = use_clear_background_i ?
                      {attr_i[7], clear_background_i, attr_i[3:0]} : attr_i;
    cmd_o.hit       = 1'b0;
    cmd_o.kind      = tcce_pkg::K_PRINT;
    unique case (op_i)
      tcce_pkg::OP_PRINT: begin
        if (char_code_i == tcce_pkg::CH_NEWLINE) begin
          cmd_o.kind = tcce_pkg::K_NEWLINE;
        end else if (char_code_i == tcce_pkg::CH_TAB) begin
          cmd_o.kind = tcce_pkg::K_TAB;
        end else begin
          cmd_o.kind = tcce_pkg::K_PRINT;
        end
      end
      tcce_pkg::OP_GOTO: begin
        cmd_o.kind = tcce_pkg::K_GOTO;
        cmd_o.hit  = goto_ok;
      end
      tcce_pkg::OP_CLEAR: begin
        cmd_o.kind = tcce_pkg::K_CLEAR;
      end
      tcce_pkg::OP_READ: begin
        cmd_o.kind = tcce_pkg::K_READ;
        cmd_o.hit  = read_ok;
      end
      default: begin
        cmd_o.kind = tcce_pkg::K_PRINT;
      end
    endcase
  end

endmodule

@@ sv/tcce_fifo.sv @@
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module tcce_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tcce_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output tcce_pkg::qhead_t head_o
);

  tcce_pkg::cmd_t ent_q [2];
  logic [1:0]     cnt_q, cnt_d;
  logic           wptr_q, rptr_q;
  logic           push_ok, pop_ok;

  assign full_o      = cnt_q == 2'd2;
  assign head_o.empty = cnt_q == 2'd0;
  assign head_o.cmd   = ent_q[rptr_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = pop_i && !head_o.empty;

  always_comb begin
    cnt_d = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_ok) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_ok) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      ent_q[wptr_q] <= cmd_i;
    end
  end

endmodule

@@ sv/tcce_back.sv @@
// Back end: cell store, cursor state and the sequencer that runs commands.
`timescale 1ns / 1ps

module tcce_back #(
  parameter int unsigned COLUMNS    = 80,
  parameter int unsigned ROWS       = 25,
  parameter int unsigned TAB_SPACES = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tcce_pkg::ATTR_W-1:0] attr_i,
  input  tcce_pkg::qhead_t            q_i,
  output logic                        q_pop_o,
  output tcce_pkg::stat_t             stat_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output tcce_pkg::res_t              res_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned PW    = $clog2(CELLS + 1);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned TW    = $clog2(TAB_SPACES + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_PUT  = 6'b000100,
    ST_COPY = 6'b001000,
    ST_FILL = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e                      state_q, state_d, fill_ret_q, fill_ret_d, nl_ret;
  logic [PW-1:0]               ptr_q, ptr_d;
  logic [tcce_pkg::ATTR_W-1:0] fill_attr_q, fill_attr_d;
  logic [CW-1:0]               col_q, col_d;
  logic [RW-1:0]               row_q, row_d;
  logic                        wrap_q, wrap_d;
  logic [TW-1:0]               tab_q, tab_d;
  logic                        cp_vld_q, cp_vld_d;
  logic [AW-1:0]               cp_addr_q, cp_addr_d;
  logic                        rd_hit_q, rd_hit_d;
  logic                        res_vld_q, res_vld_d;
  tcce_pkg::res_t              res_q, res_d;
  tcce_pkg::cmd_t              cmd_q, cmd_d;

  logic [tcce_pkg::DATA_W-1:0] mem [CELLS];
  logic [tcce_pkg::DATA_W-1:0] mem_rdata_q;
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [tcce_pkg::DATA_W-1:0] mem_wdata;

  logic [RW-1:0]               row_m1;
  logic [AW-1:0]               row_base, pos;
  logic                        col_last;
  logic                        nl_req;
  logic                        res_load;
  logic [tcce_pkg::CHAR_W-1:0] put_chr;

  assign row_m1   = row_q - 1'b1;
  assign row_base = AW'(row_m1 * COLUMNS);
  assign pos      = row_base + AW'(col_q - 1'b1);
  assign col_last = col_q == CW'(COLUMNS);
  assign nl_ret   = (cmd_q.kind == tcce_pkg::K_NEWLINE) ? ST_DONE : ST_PUT;
  assign put_chr  = (cmd_q.kind == tcce_pkg::K_TAB) ? tcce_pkg::CH_SPACE : cmd_q.chr;

  assign q_pop_o          = (state_q == ST_IDLE) && !q_i.empty;
  assign stat_o.init_busy = (state_q == ST_FILL) && (fill_ret_q == ST_IDLE);
  assign empty_o          = !res_vld_q;
  assign res_o            = res_q;

  always_comb begin
    state_d     = state_q;
    fill_ret_d  = fill_ret_q;
    ptr_d       = ptr_q;
    fill_attr_d = fill_attr_q;
    col_d       = col_q;
    row_d       = row_q;
    wrap_d      = wrap_q;
    tab_d       = tab_q;
    cp_vld_d    = 1'b0;
    cp_addr_d   = AW'(ptr_q);
    rd_hit_d    = rd_hit_q;
    cmd_d       = cmd_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    nl_req      = 1'b0;
    res_load    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_i.empty) begin
          cmd_d   = q_i.cmd;
          tab_d   = (q_i.cmd.kind == tcce_pkg::K_TAB) ? TW'(TAB_SPACES) : TW'(1);
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_hit_d = (cmd_q.kind == tcce_pkg::K_READ) && cmd_q.hit;
        unique case (cmd_q.kind) inside
          tcce_pkg::K_PRINT, tcce_pkg::K_TAB: begin
            wrap_d = 1'b0;
            if (wrap_q && col_last) begin
              nl_req = 1'b1;
            end else begin
              state_d = ST_PUT;
            end
          end
          tcce_pkg::K_NEWLINE: begin
            wrap_d = 1'b0;
            nl_req = 1'b1;
          end
          tcce_pkg::K_GOTO: begin
            if (cmd_q.hit) begin
              col_d = CW'(cmd_q.col);
              row_d = RW'(cmd_q.row);
            end
            state_d = ST_DONE;
          end
          tcce_pkg::K_CLEAR: begin
            col_d       = CW'(1);
            row_d       = RW'(1);
            ptr_d       = '0;
            fill_attr_d = cmd_q.fill_attr;
            fill_ret_d  = ST_DONE;
            state_d     = ST_FILL;
          end
          tcce_pkg::K_READ: begin
            mem_re    = cmd_q.hit;
            mem_raddr = AW'(cmd_q.idx);
            state_d   = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
        if (nl_req) begin
          col_d = CW'(1);
          if (row_q != RW'(ROWS)) begin
            row_d   = row_q + 1'b1;
            state_d = nl_ret;
          end else begin
            ptr_d   = '0;
            state_d = ST_COPY;
          end
        end
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
        mem_wdata = {attr_i, put_chr};
        if (col_last) begin
          wrap_d = 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        if (tab_q > TW'(1)) begin
          tab_d   = tab_q - 1'b1;
          state_d = ST_EXEC;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_COPY: begin
        // read one row ahead, write back the word read in the previous cycle
        mem_we    = cp_vld_q;
        mem_waddr = cp_addr_q;
        mem_wdata = mem_rdata_q;
        if (ptr_q < PW'(CELLS - COLUMNS)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr_q + PW'(COLUMNS));
          cp_vld_d  = 1'b1;
          ptr_d     = ptr_q + 1'b1;
        end else begin
          fill_attr_d = attr_i;
          fill_ret_d  = nl_ret;
          state_d     = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_q);
        mem_wdata = {fill_attr_q, tcce_pkg::CH_SPACE};
        if (ptr_q == PW'(CELLS - 1)) begin
          state_d = fill_ret_q;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!res_vld_q || pop_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_d        = res_q;
    res_vld_d    = res_vld_q;
    if (res_load) begin
      res_vld_d    = 1'b1;
      res_d.col    = tcce_pkg::COL_W'(col_q);
      res_d.row    = tcce_pkg::ROW_W'(row_q);
      res_d.offset = tcce_pkg::OFF_W'(pos);
      res_d.wrap   = wrap_q;
      res_d.rdata  = (cmd_q.kind == tcce_pkg::K_READ && rd_hit_q) ? mem_rdata_q : '0;
    end else if (pop_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_ret_q  <= ST_IDLE;
      ptr_q       <= '0;
      fill_attr_q <= tcce_pkg::ATTR_RESET;
      col_q       <= CW'(1);
      row_q       <= RW'(1);
      wrap_q      <= 1'b0;
      tab_q       <= '0;
      cp_vld_q    <= 1'b0;
      rd_hit_q    <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_ret_q  <= fill_ret_d;
      ptr_q       <= ptr_d;
      fill_attr_q <= fill_attr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      wrap_q      <= wrap_d;
      tab_q       <= tab_d;
      cp_vld_q    <= cp_vld_d;
      rd_hit_q    <= rd_hit_d;
      res_vld_q   <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
    cmd_q     <= cmd_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

endmodule

@@ sv/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine: config registers, front, queue, back.
// Sequence for an accepted word: a printable char is dequeued, decoded, written and
//   returned; a newline skips the write and, on a scroll, first copies the rows up and
//   blanks the last row; a tab writes TAB_SPACES spaces; a clear blanks the store. The
//   back end dequeues only once the last result is loaded; the queue holds two words.
// Reset: cursor 1,1, wrap clear, white on black; full held high during the store clear.
`timescale 1ns / 1ps

module text_console_cursor_engine #(
  parameter int unsigned COLUMNS    = 80,
  parameter int unsigned ROWS       = 25,
  parameter int unsigned TAB_SPACES = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [tcce_pkg::OP_W-1:0]       op_i,
  input  logic [tcce_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcce_pkg::COL_W-1:0]      column_i,
  input  logic [tcce_pkg::ROW_W-1:0]      row_i,
  input  logic [tcce_pkg::BG_W-1:0]       clear_background_i,
  input  logic                            use_clear_background_i,
  input  logic [tcce_pkg::IDX_W-1:0]      cell_index_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [tcce_pkg::COL_W-1:0]      cursor_col_o,
  output logic [tcce_pkg::ROW_W-1:0]      cursor_row_o,
  output logic [tcce_pkg::OFF_W-1:0]      cursor_offset_o,
  output logic                            wrap_pending_o,
  output logic [tcce_pkg::DATA_W-1:0]     read_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [tcce_pkg::FG_W-1:0]   text_color_q;
  logic [tcce_pkg::BG_W-1:0]   back_color_q;
  logic [tcce_pkg::ATTR_W-1:0] attr;
  tcce_pkg::cmd_t              cmd;
  tcce_pkg::qhead_t            qhead;
  tcce_pkg::stat_t             stat;
  tcce_pkg::res_t              res;
  logic                        q_full;
  logic                        q_pop;

  assign attr        = {1'b0, back_color_q, text_color_q};
  assign cfg_ready_o = 1'b1;
  assign full        = q_full || stat.init_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcce_pkg::FG_RESET;
      back_color_q <= tcce_pkg::BG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tcce_pkg::CFG_TEXT_COLOR: text_color_q <= cfg_data_i;
        tcce_pkg::CFG_BACK_COLOR: back_color_q <= cfg_data_i[tcce_pkg::BG_W-1:0];
        default: ;
      endcase
    end
  end

  tcce_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .op_i                  (op_i),
    .char_code_i           (char_code_i),
    .column_i              (column_i),
    .row_i                 (row_i),
    .clear_background_i    (clear_background_i),
    .use_clear_background_i(use_clear_background_i),
    .cell_index_i          (cell_index_i),
    .attr_i                (attr),
    .cmd_o                 (cmd)
  );

  tcce_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push && !full),
    .cmd_i (cmd),
    .full_o(q_full),
    .pop_i (q_pop),
    .head_o(qhead)
  );

  tcce_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_SPACES(TAB_SPACES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .attr_i (attr),
    .q_i    (qhead),
    .q_pop_o(q_pop),
    .stat_o (stat),
    .empty_o(empty),
    .pop_i  (pop),
    .res_o  (res)
  );

  assign cursor_col_o    = res.col;
  assign cursor_row_o    = res.row;
  assign cursor_offset_o = res.offset;
  assign wrap_pending_o  = res.wrap;
  assign read_data_o     = res.rdata;

endmodule

@@ sv/tcce_checker.sv @@
// Port-level assertions for the text console cursor engine, bound to the top level.
`timescale 1ns / 1ps

module tcce_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [tcce_pkg::COL_W-1:0]  cursor_col_o,
  input logic [tcce_pkg::ROW_W-1:0]  cursor_row_o,
  input logic [tcce_pkg::OFF_W-1:0]  cursor_offset_o,
  input logic [tcce_pkg::DATA_W-1:0] read_data_o
);

  localparam bit EXACT = (COLUMNS < 128) && (ROWS < 32);

  logic [tcce_pkg::OFF_W-1:0] exp_off;

  assign exp_off = tcce_pkg::OFF_W'((32'(cursor_col_o) - 32'd1) +
                                    (32'(cursor_row_o) - 32'd1) * COLUMNS);

  a_init_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> full)
    else $error("input not blocked during clearing pass");

  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && EXACT |-> cursor_offset_o == exp_off)
    else $error("cursor offset does not match column and row");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && EXACT |-> cursor_col_o != '0 && 32'(cursor_col_o) <= COLUMNS &&
                        cursor_row_o != '0 && 32'(cursor_row_o) <= ROWS)
    else $error("cursor outside screen");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(cursor_offset_o) && $stable(read_data_o))
    else $error("waiting result changed");

endmodule

bind text_console_cursor_engine tcce_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcce_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for the text console cursor engine: directed table, then random words.
`timescale 1ns / 1ps

module tb_top;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int TAB_WIDTH   = 5;
  localparam int CELL_TOTAL  = SCREEN_COLS * SCREEN_ROWS;
  localparam int SEG_COUNT   = 6;
  localparam int SEG_WORDS   = 240;
  localparam int HOLD_CYCLES = 400;
  // worst case: every word a full store pass plus long stalls, taken several times over
  localparam int LIMIT_CYCLES = 15_000_000;
  localparam int SCRIPT_LEN  = 25;

  typedef struct packed {
    logic [tcce_pkg::OP_W-1:0]   op;
    logic [tcce_pkg::CHAR_W-1:0] chr;
    logic [tcce_pkg::COL_W-1:0]  col;
    logic [tcce_pkg::ROW_W-1:0]  row;
    logic [tcce_pkg::BG_W-1:0]   bg;
    logic                        use_bg;
    logic [tcce_pkg::IDX_W-1:0]  idx;
  } console_cmd_t;

  typedef struct packed {
    console_cmd_t   cmd;
    logic           typed;
    tcce_pkg::res_t want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [tcce_pkg::OP_W-1:0] op_i = tcce_pkg::OP_READ;
  logic [tcce_pkg::CHAR_W-1:0] char_code_i = '0;
  logic [tcce_pkg::COL_W-1:0] column_i = '0;
  logic [tcce_pkg::ROW_W-1:0] row_i = '0;
  logic [tcce_pkg::BG_W-1:0] clear_background_i = '0;
  logic use_clear_background_i = 1'b0;
  logic [tcce_pkg::IDX_W-1:0] cell_index_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [tcce_pkg::COL_W-1:0] cursor_col_o;
  logic [tcce_pkg::ROW_W-1:0] cursor_row_o;
  logic [tcce_pkg::OFF_W-1:0] cursor_offset_o;
  logic wrap_pending_o;
  logic [tcce_pkg::DATA_W-1:0] read_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index_i = tcce_pkg::CFG_TEXT_COLOR;
  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  text_console_cursor_engine #(
    .COLUMNS   (SCREEN_COLS),
    .ROWS      (SCREEN_ROWS),
    .TAB_SPACES(TAB_WIDTH)
  ) u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .push                  (push),
    .full                  (full),
    .op_i                  (op_i),
    .char_code_i           (char_code_i),
    .column_i              (column_i),
    .row_i                 (row_i),
    .clear_background_i    (clear_background_i),
    .use_clear_background_i(use_clear_background_i),
    .cell_index_i          (cell_index_i),
    .empty                 (empty),
    .pop                   (pop),
    .cursor_col_o          (cursor_col_o),
    .cursor_row_o          (cursor_row_o),
    .cursor_offset_o       (cursor_offset_o),
    .wrap_pending_o        (wrap_pending_o),
    .read_data_o           (read_data_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // screen model
  logic [tcce_pkg::DATA_W-1:0] screen_model [CELL_TOTAL];
  logic [tcce_pkg::COL_W-1:0]  cur_col;
  logic [tcce_pkg::ROW_W-1:0]  cur_line;
  logic                        wrap_armed;
  logic [tcce_pkg::FG_W-1:0]   text_color_reg;
  logic [tcce_pkg::BG_W-1:0]   back_color_reg;

  tcce_pkg::res_t cursor_results [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_gap_pct = 0;
  int   pop_gap_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  tcce_pkg::res_t want_res;

  script_row_t script_rows [SCRIPT_LEN] = '{
    '{'{tcce_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b1,
      '{7'd1, 5'd1, 11'd0, 1'b0, 16'h0F20}},
    '{'{tcce_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 3'd0, 1'b0, 11'd2047}, 1'b1,
      '{7'd1, 5'd1, 11'd0, 1'b0, 16'h0000}},
    '{'{tcce_pkg::OP_PRINT, 8'h41, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b1,
      '{7'd2, 5'd1, 11'd1, 1'b0, 16'h0000}},
    '{'{tcce_pkg::OP_PRINT, 8'h00, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_PRINT, 8'hFF, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 3'd0, 1'b0, 11'd2}, 1'b0, '0},
    '{'{tcce_pkg::OP_GOTO, 8'h00, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_GOTO, 8'h00, 7'd81, 5'd26, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_GOTO, 8'h00, 7'd127, 5'd31, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_GOTO, 8'h00, 7'd80, 5'd25, 3'd0, 1'b0, 11'd0}, 1'b1,
      '{7'd80, 5'd25, 11'd1999, 1'b0, 16'h0000}},
    '{'{tcce_pkg::OP_PRINT, 8'h5A, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b1,
      '{7'd80, 5'd25, 11'd1999, 1'b1, 16'h0000}},
    '{'{tcce_pkg::OP_PRINT, 8'h62, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_GOTO, 8'h00, 7'd80, 5'd25, 3'd0, 1'b0, 11'd0}, 1'b1,
      '{7'd80, 5'd25, 11'd1999, 1'b0, 16'h0000}},
    '{'{tcce_pkg::OP_PRINT, 8'h63, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_PRINT, tcce_pkg::CH_NEWLINE, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_GOTO, 8'h00, 7'd80, 5'd1, 3'd0, 1'b0, 11'd0}, 1'b1,
      '{7'd80, 5'd1, 11'd79, 1'b0, 16'h0000}},
    '{'{tcce_pkg::OP_PRINT, 8'h7E, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_GOTO, 8'h00, 7'd5, 5'd5, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_PRINT, 8'h71, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_GOTO, 8'h00, 7'd77, 5'd24, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_PRINT, tcce_pkg::CH_TAB, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_CLEAR, 8'h00, 7'd0, 5'd0, 3'd7, 1'b1, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 3'd0, 1'b0, 11'd1999}, 1'b0, '0},
    '{'{tcce_pkg::OP_CLEAR, 8'h00, 7'd0, 5'd0, 3'd5, 1'b0, 11'd0}, 1'b0, '0},
    '{'{tcce_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 3'd0, 1'b0, 11'd0}, 1'b0, '0}
  };

  function automatic logic [tcce_pkg::ATTR_W-1:0] attr_now();
    return {1'b0, back_color_reg, text_color_reg};
  endfunction

  function automatic logic [tcce_pkg::OFF_W-1:0] cursor_offset();
    return tcce_pkg::OFF_W'(cur_col - 1) +
           tcce_pkg::OFF_W'(cur_line - 1) * tcce_pkg::OFF_W'(SCREEN_COLS);
  endfunction

  function automatic void blank_from(int first, logic [tcce_pkg::ATTR_W-1:0] attr);
    for (int i = first; i < CELL_TOTAL; i++) screen_model[i] = {attr, tcce_pkg::CH_SPACE};
  endfunction

  function automatic void line_feed();
    if (cur_line < SCREEN_ROWS) begin
      cur_line = cur_line + 1'b1;
    end else begin
      for (int i = 0; i < CELL_TOTAL - SCREEN_COLS; i++)
        screen_model[i] = screen_model[i + SCREEN_COLS];
      blank_from(CELL_TOTAL - SCREEN_COLS, attr_now());
    end
    cur_col = 7'd1;
  endfunction

  function automatic void put_glyph(logic [tcce_pkg::CHAR_W-1:0] c);
    if (wrap_armed) begin
      if (cur_col == SCREEN_COLS) line_feed();
      wrap_armed = 1'b0;
    end
    screen_model[cursor_offset()] = {attr_now(), c};
    if (cur_col == SCREEN_COLS) wrap_armed = 1'b1;
    else cur_col = cur_col + 1'b1;
  endfunction

  function automatic tcce_pkg::res_t apply_cmd(console_cmd_t c);
    tcce_pkg::res_t r;
    logic [tcce_pkg::ATTR_W-1:0] fill;
    r = '0;
    case (c.op)
      tcce_pkg::OP_PRINT: begin
        if (c.chr == tcce_pkg::CH_NEWLINE) begin
          line_feed();
          wrap_armed = 1'b0;
        end else if (c.chr == tcce_pkg::CH_TAB) begin
          for (int i = 0; i < TAB_WIDTH; i++) put_glyph(tcce_pkg::CH_SPACE);
        end else begin
          put_glyph(c.chr);
        end
      end
      tcce_pkg::OP_GOTO: begin
        if (c.col >= 1 && c.col <= SCREEN_COLS && c.row >= 1 && c.row <= SCREEN_ROWS) begin
          cur_col = c.col;
          cur_line = c.row;
        end
      end
      tcce_pkg::OP_CLEAR: begin
        fill = attr_now();
        if (c.use_bg) fill[6:4] = c.bg;
        blank_from(0, fill);
        cur_col = 7'd1;
        cur_line = 5'd1;
      end
      default: begin
        if (c.idx < CELL_TOTAL) r.rdata = screen_model[c.idx];
      end
    endcase
    r.col = cur_col;
    r.row = cur_line;
    r.offset = cursor_offset();
    r.wrap = wrap_armed;
    return r;
  endfunction

  function automatic console_cmd_t random_cmd(bit calm);
    console_cmd_t c;
    int k;
    c.chr = tcce_pkg::CHAR_W'($urandom_range(255));
    c.col = tcce_pkg::COL_W'($urandom_range(127));
    c.row = tcce_pkg::ROW_W'($urandom_range(31));
    c.bg = tcce_pkg::BG_W'($urandom_range(7));
    c.use_bg = 1'($urandom_range(1));
    c.idx = tcce_pkg::IDX_W'($urandom_range(2047));
    k = calm ? 50 + $urandom_range(49) : $urandom_range(99);
    if (calm && k < 75) begin
      c.op = tcce_pkg::OP_READ;
      c.idx = tcce_pkg::IDX_W'($urandom_range(CELL_TOTAL - 1));
    end else if (k < 66) begin
      c.op = tcce_pkg::OP_PRINT;
    end else if (k < 70) begin
      c.op = tcce_pkg::OP_PRINT;
      c.chr = tcce_pkg::CH_NEWLINE;
    end else if (k < 74) begin
      c.op = tcce_pkg::OP_PRINT;
      c.chr = tcce_pkg::CH_TAB;
    end else if (k < 86 || calm) begin
      c.op = tcce_pkg::OP_GOTO;
      if ($urandom_range(99) < 30) begin
        c.col = tcce_pkg::COL_W'($urandom_range(SCREEN_COLS, SCREEN_COLS - 10));
        c.row = tcce_pkg::ROW_W'($urandom_range(SCREEN_ROWS, SCREEN_ROWS - 5));
      end else if ($urandom_range(99) < 75) begin
        c.col = tcce_pkg::COL_W'($urandom_range(SCREEN_COLS, 1));
        c.row = tcce_pkg::ROW_W'($urandom_range(SCREEN_ROWS, 1));
      end
    end else if (k < 87) begin
      c.op = tcce_pkg::OP_CLEAR;
    end else begin
      c.op = tcce_pkg::OP_READ;
      if ($urandom_range(99) < 85)
        c.idx = tcce_pkg::IDX_W'($urandom_range(CELL_TOTAL - 1));
    end
    return c;
  endfunction

  task automatic send_cmd(console_cmd_t c, logic typed, tcce_pkg::res_t typed_res);
    tcce_pkg::res_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= c.op;
    char_code_i <= c.chr;
    column_i <= c.col;
    row_i <= c.row;
    clear_background_i <= c.bg;
    use_clear_background_i <= c.use_bg;
    cell_index_i <= c.idx;
    do @(posedge clk_i); while (full);
    r = apply_cmd(c);
    cursor_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (cursor_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_colors(logic [tcce_pkg::FG_W-1:0] fg, logic [tcce_pkg::BG_W-1:0] bg);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= tcce_pkg::CFG_TEXT_COLOR;
    cfg_data_i <= fg;
    do @(posedge clk_i); while (!cfg_ready_o);
    text_color_reg = fg;
    cfg_index_i <= tcce_pkg::CFG_BACK_COLOR;
    cfg_data_i <= tcce_pkg::CFG_DATA_W'(bg);
    do @(posedge clk_i); while (!cfg_ready_o);
    back_color_reg = bg;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(string name, logic [tcce_pkg::DATA_W-1:0] want,
                             logic [tcce_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (cursor_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, got col %0d row %0d", $time,
                 cursor_col_o, cursor_row_o);
        mismatch_count++;
      end else begin
        want_res = cursor_results.pop_front();
        check_field("cursor_col", tcce_pkg::DATA_W'(want_res.col),
                    tcce_pkg::DATA_W'(cursor_col_o));
        check_field("cursor_row", tcce_pkg::DATA_W'(want_res.row),
                    tcce_pkg::DATA_W'(cursor_row_o));
        check_field("cursor_offset", tcce_pkg::DATA_W'(want_res.offset),
                    tcce_pkg::DATA_W'(cursor_offset_o));
        check_field("wrap_pending", tcce_pkg::DATA_W'(want_res.wrap),
                    tcce_pkg::DATA_W'(wrap_pending_o));
        check_field("read_data", want_res.rdata, read_data_o);
      end
    end
    if (hold_req && !hold_done) begin
      pop <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= pop_gap_pct);
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("text_console_cursor_engine regression: fail");
    $finish;
  end

  initial begin
    text_color_reg = tcce_pkg::FG_RESET;
    back_color_reg = tcce_pkg::BG_RESET;
    cur_col = 7'd1;
    cur_line = 5'd1;
    wrap_armed = 1'b0;
    blank_from(0, tcce_pkg::ATTR_RESET);
    send_gap_pct = 8;
    pop_gap_pct <= 88;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script_rows[i])
      send_cmd(script_rows[i].cmd, script_rows[i].typed, script_rows[i].want);

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      drain();
      if (seg == 0) set_colors(4'd0, 3'd7);
      else if (seg == 1) set_colors(4'd15, 3'd0);
      else set_colors(tcce_pkg::FG_W'($urandom_range(15)), tcce_pkg::BG_W'($urandom_range(7)));
      case (seg / 2)
        0: begin
          send_gap_pct = 8;
          pop_gap_pct <= 88;
        end
        1: begin
          send_gap_pct = 88;
          pop_gap_pct <= 8;
        end
        default: begin
          send_gap_pct = 0;
          pop_gap_pct <= 0;
        end
      endcase
      // receiver backs off while quick words keep coming
      if (seg == 4) hold_req <= 1'b1;
      for (int n = 0; n < SEG_WORDS; n++)
        send_cmd(random_cmd(seg == 4 && n < 80), 1'b0, '0);
    end

    drain();
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0 && cursor_results.size() == 0)
      $display("text_console_cursor_engine regression: pass");
    else
      $display("text_console_cursor_engine regression: fail");
    $finish;
  end

endmodule
